@@ hdl/assert_macros.svh @@
// Assertion macros shared by the tone generator modules.
// No dependencies; compiled away when NO_ASSERTIONS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ON(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
	else $error("forbidden condition seen");
`else
`define ASSERT_ON(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

@@ hdl/stg_pkg.sv @@
// Shared types and constants of the sine tone generator.
// Used by stg_ctrl, stg_datapath and the top level; no dependencies.
package stg_pkg;

	localparam int PHASE_W    = 32;
	localparam int TABLE_BITS = 10;
	localparam int Q_FRAC     = 30;
	localparam int ANG_W      = Q_FRAC + 1;
	localparam int PROD_W     = 2 * ANG_W;
	localparam int AMP_W      = 15;
	localparam int LEN_W      = 13;
	localparam int CHCFG_W    = 4;
	localparam int CHAN_W     = 3;
	localparam int CNT_W      = 12;
	localparam int SUM_W      = 42;
	localparam int SAMPLE_W   = 16;
	localparam int ROOT_W     = SUM_W / 2;
	localparam int SREM_W     = ROOT_W + 2;
	localparam int DIV_STEPS  = SUM_W;
	localparam int STEP_W     = 6;
	localparam int MUL_IDX_W  = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [ANG_W-1:0] Q30_ONE = ANG_W'(64'd1 << Q_FRAC);
	localparam logic [Q_FRAC-1:0] IDX_MASK =
		Q_FRAC'((64'd1 << Q_FRAC) - (64'd1 << (PHASE_W - TABLE_BITS)));
	localparam logic [ANG_W-1:0] PC1 = 31'd1686629713;
	localparam logic [ANG_W-1:0] PC3 = 31'd693598668;
	localparam logic [ANG_W-1:0] PC5 = 31'd85569306;
	localparam logic [ANG_W-1:0] PC7 = 31'd5026995;
	localparam logic [ANG_W-1:0] PC9 = 31'd172272;

	localparam logic [AMP_W-1:0]   FULL_SCALE   = 15'd32767;
	localparam logic [LEN_W-1:0]   MAX_CHUNK    = 13'd4096;
	localparam logic [CHCFG_W-1:0] MAX_CHANNELS = 4'd8;

	localparam logic [PHASE_W-1:0] RST_PHASE_INC = 32'd39370534;
	localparam logic [AMP_W-1:0]   RST_AMPLITUDE = 15'd16384;
	localparam logic [LEN_W-1:0]   RST_CHUNK_LEN = 13'd960;
	localparam logic [CHCFG_W-1:0] RST_CHAN_CNT  = 4'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PHASE_INC,
		CFG_AMPLITUDE,
		CFG_CHUNK_LEN,
		CFG_CHAN_COUNT
	} cfg_reg_t;

	typedef enum logic [2:0] {
		DP_NOP,
		DP_LOAD,
		DP_MUL,
		DP_WB,
		DP_DIV,
		DP_ROOT
	} dp_op_t;

	typedef enum logic [MUL_IDX_W-1:0] {
		MS_TT,
		MS_R7,
		MS_R5,
		MS_R3,
		MS_R1,
		MS_S,
		MS_M,
		MS_SCALE,
		MS_SQUARE
	} mul_step_t;

	typedef struct packed {
		dp_op_t    op;
		mul_step_t step;
		logic      advance;
	} dp_cmd_t;

	typedef struct packed {
		logic chunk_end;
		logic last_chan;
	} dp_sts_t;

endpackage

@@ hdl/stg_ctrl.sv @@
// Sequencer of the tone generator: steps the shared multiplier, divider and root.
// Depends on stg_pkg and assert_macros.svh.
`include "assert_macros.svh"
module stg_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_tick,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  stg_pkg::dp_sts_t sts,
	output stg_pkg::dp_cmd_t cmd
);
	import stg_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_WB,
		ST_DIV,
		ST_ROOT,
		ST_FIN,
		ST_EMIT
	} state_t;

	state_t              state_q;
	logic [STEP_W-1:0]   step_q;
	dp_op_t              op_q;
	mul_step_t           mstep_q;
	logic                in_ready_q;
	logic                out_valid_q;
	logic                out_fire;

	assign out_fire  = out_valid_q & out_ready;
	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;
	assign cmd       = '{op: op_q, step: mstep_q, advance: out_fire};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			op_q        <= DP_NOP;
			mstep_q     <= MS_TT;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			op_q <= DP_NOP;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready_q && in_tick) begin
						op_q       <= DP_LOAD;
						in_ready_q <= 1'b0;
						step_q     <= '0;
						state_q    <= ST_MUL;
					end
				end
				ST_MUL: begin
					op_q    <= DP_MUL;
					mstep_q <= mul_step_t'(step_q[MUL_IDX_W-1:0]);
					state_q <= ST_WB;
				end
				ST_WB: begin
					op_q <= DP_WB;
					if (mstep_q == MS_SQUARE) begin
						step_q  <= '0;
						state_q <= sts.chunk_end ? ST_DIV : ST_FIN;
					end else begin
						step_q  <= step_q + STEP_W'(1);
						state_q <= ST_MUL;
					end
				end
				ST_DIV: begin
					op_q <= DP_DIV;
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						step_q  <= '0;
						state_q <= ST_ROOT;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_ROOT: begin
					op_q <= DP_ROOT;
					if (step_q == STEP_W'(ROOT_W - 1)) begin
						step_q  <= '0;
						state_q <= ST_FIN;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_FIN: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_fire && sts.last_chan) begin
						out_valid_q <= 1'b0;
						in_ready_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_NEVER(a_ready_while_emit, clk, arst_n, in_ready_q && out_valid_q)
	`ASSERT_ON(a_tick_loads, clk, arst_n, (in_valid && in_ready_q && in_tick) |=> (op_q == DP_LOAD && !in_ready_q))
	`ASSERT_ON(a_div_on_end, clk, arst_n, (state_q == ST_DIV) |-> sts.chunk_end)

endmodule

@@ hdl/stg_datapath.sv @@
// Datapath of the tone generator: config registers, phase, shared multiplier,
// statistics, bit-serial divider and square root. Depends on stg_pkg.
`include "assert_macros.svh"
module stg_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [stg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [stg_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  stg_pkg::dp_cmd_t                  cmd,
	output stg_pkg::dp_sts_t                  sts,
	output logic signed [stg_pkg::SAMPLE_W-1:0] sample,
	output logic [stg_pkg::CHAN_W-1:0]        channel_index,
	output logic                              chunk_end,
	output logic [stg_pkg::AMP_W-1:0]         peak_level,
	output logic [stg_pkg::AMP_W-1:0]         rms_level
);
	import stg_pkg::*;

	logic [PHASE_W-1:0]  inc_q;
	logic [AMP_W-1:0]    amp_q;
	logic [LEN_W-1:0]    len_q;
	logic [CHCFG_W-1:0]  chans_q;

	logic [PHASE_W-1:0]  phase_q;
	logic [CNT_W-1:0]    count_q;
	logic [AMP_W-1:0]    peak_q;
	logic [SUM_W-1:0]    sum_q;
	logic                end_q;
	logic [CHAN_W-1:0]   chan_q;

	logic [ANG_W-1:0]    t_q;
	logic [ANG_W-1:0]    u_q;
	logic [ANG_W-1:0]    r_q;
	logic [AMP_W-1:0]    mag_q;
	logic [AMP_W-1:0]    smag_q;
	logic                neg_q;
	logic [PROD_W-1:0]   prod_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [AMP_W-1:0]    pk_q;
	logic [SUM_W-1:0]    work_q;
	logic [LEN_W-1:0]    drem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [SREM_W-1:0]   srem_q;

	logic [LEN_W-1:0]    len_eff;
	logic [CHCFG_W-1:0]  chans_eff;
	logic                last_chan;
	logic [ANG_W-1:0]    t_low;
	logic [ANG_W-1:0]    t_next;
	logic [ANG_W-1:0]    op_a;
	logic [ANG_W-1:0]    op_b;
	logic [ANG_W-1:0]    pc_sel;
	logic [ANG_W-1:0]    prod_hi;
	logic [46:0]         m_round;
	logic [16:0]         m_val;
	logic [AMP_W-1:0]    mag_next;
	logic [AMP_W-1:0]    q0;
	logic [AMP_W:0]      rem16;
	logic [AMP_W-1:0]    smag_next;
	logic [SAMPLE_W-1:0] smag_ext;
	logic [SUM_W-1:0]    sum_new;
	logic [AMP_W-1:0]    peak_new;
	logic [LEN_W:0]      dsh;
	logic [LEN_W:0]      ddiff;
	logic                dge;
	logic [SREM_W+1:0]   rsh;
	logic [SREM_W+1:0]   trial;
	logic [SREM_W+1:0]   rdiff;
	logic                rge;

	always_comb begin
		if (len_q == '0)
			len_eff = LEN_W'(1);
		else if (len_q > MAX_CHUNK)
			len_eff = MAX_CHUNK;
		else
			len_eff = len_q;
		if (chans_q == '0)
			chans_eff = CHCFG_W'(1);
		else if (chans_q > MAX_CHANNELS)
			chans_eff = MAX_CHANNELS;
		else
			chans_eff = chans_q;
	end

	assign last_chan = (CHCFG_W'(chan_q) == (chans_eff - CHCFG_W'(1)));

	assign t_low  = {1'b0, phase_q[Q_FRAC-1:0] & IDX_MASK};
	assign t_next = phase_q[PHASE_W-2] ? (Q30_ONE - t_low) : t_low;

	always_comb begin
		case (cmd.step)
			MS_TT: begin
				op_a = t_q;
				op_b = t_q;
			end
			MS_R7, MS_R5, MS_R3, MS_R1: begin
				op_a = u_q;
				op_b = r_q;
			end
			MS_S: begin
				op_a = t_q;
				op_b = r_q;
			end
			MS_M: begin
				op_a = r_q;
				op_b = ANG_W'(FULL_SCALE);
			end
			MS_SCALE: begin
				op_a = ANG_W'(mag_q);
				op_b = ANG_W'(amp_q);
			end
			MS_SQUARE: begin
				op_a = ANG_W'(smag_q);
				op_b = ANG_W'(smag_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
		case (cmd.step)
			MS_R7:   pc_sel = PC7;
			MS_R5:   pc_sel = PC5;
			MS_R3:   pc_sel = PC3;
			MS_R1:   pc_sel = PC1;
			default: pc_sel = '0;
		endcase
	end

	assign prod_hi  = prod_q[Q_FRAC+ANG_W-1:Q_FRAC];
	assign m_round  = prod_q[46:0] + 47'(64'd1 << (Q_FRAC - 1));
	assign m_val    = m_round[46:Q_FRAC];
	assign mag_next = (m_val > 17'(FULL_SCALE)) ? FULL_SCALE : m_val[AMP_W-1:0];

	// divide by full scale: quotient estimate from the upper half, one correction
	assign q0        = prod_q[2*AMP_W-1:AMP_W];
	assign rem16     = {1'b0, prod_q[AMP_W-1:0]} + {1'b0, q0};
	assign smag_next = q0 + ((rem16 >= {1'b0, FULL_SCALE}) ? AMP_W'(1) : AMP_W'(0));
	assign smag_ext  = {1'b0, smag_next};

	assign sum_new  = sum_q + SUM_W'(prod_q[2*AMP_W-1:0]);
	assign peak_new = (smag_q > peak_q) ? smag_q : peak_q;

	assign dsh   = {drem_q, work_q[SUM_W-1]};
	assign ddiff = dsh - {1'b0, len_eff};
	assign dge   = (dsh >= {1'b0, len_eff});

	assign rsh   = {srem_q, work_q[SUM_W-1:SUM_W-2]};
	assign trial = (SREM_W+2)'({root_q, 2'b01});
	assign rdiff = rsh - trial;
	assign rge   = (rsh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q   <= RST_PHASE_INC;
			amp_q   <= RST_AMPLITUDE;
			len_q   <= RST_CHUNK_LEN;
			chans_q <= RST_CHAN_CNT;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_PHASE_INC:  inc_q   <= cfg_data;
				CFG_AMPLITUDE:  amp_q   <= cfg_data[AMP_W-1:0];
				CFG_CHUNK_LEN:  len_q   <= cfg_data[LEN_W-1:0];
				CFG_CHAN_COUNT: chans_q <= cfg_data[CHCFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			count_q <= '0;
			peak_q  <= '0;
			sum_q   <= '0;
			end_q   <= 1'b0;
			chan_q  <= '0;
		end else begin
			case (cmd.op)
				DP_LOAD: begin
					phase_q <= phase_q + inc_q;
					end_q   <= ((LEN_W'(count_q) + LEN_W'(1)) >= len_eff);
					chan_q  <= '0;
				end
				DP_WB: begin
					if (cmd.step == MS_SQUARE) begin
						if (end_q) begin
							count_q <= '0;
							peak_q  <= '0;
							sum_q   <= '0;
						end else begin
							count_q <= count_q + CNT_W'(1);
							peak_q  <= peak_new;
							sum_q   <= sum_new;
						end
					end
				end
				default: ;
			endcase
			if (cmd.advance)
				chan_q <= last_chan ? '0 : chan_q + CHAN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD: begin
				t_q   <= t_next;
				neg_q <= phase_q[PHASE_W-1];
				r_q   <= PC9;
			end
			DP_MUL: begin
				prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
			end
			DP_WB: begin
				case (cmd.step)
					MS_TT:                      u_q <= prod_hi;
					MS_R7, MS_R5, MS_R3, MS_R1: r_q <= pc_sel - prod_hi;
					MS_S:                       r_q <= prod_hi;
					MS_M:                       mag_q <= mag_next;
					MS_SCALE: begin
						smag_q   <= smag_next;
						sample_q <= neg_q ? (~smag_ext + SAMPLE_W'(1)) : smag_ext;
					end
					MS_SQUARE: begin
						if (end_q) begin
							pk_q   <= peak_new;
							work_q <= sum_new;
							drem_q <= '0;
							root_q <= '0;
							srem_q <= '0;
						end
					end
					default: ;
				endcase
			end
			DP_DIV: begin
				drem_q <= dge ? ddiff[LEN_W-1:0] : dsh[LEN_W-1:0];
				work_q <= {work_q[SUM_W-2:0], dge};
			end
			DP_ROOT: begin
				srem_q <= rge ? rdiff[SREM_W-1:0] : rsh[SREM_W-1:0];
				root_q <= {root_q[ROOT_W-2:0], rge};
				work_q <= {work_q[SUM_W-3:0], 2'b00};
			end
			default: ;
		endcase
	end

	assign sts.chunk_end = end_q;
	assign sts.last_chan = last_chan;
	assign sample        = sample_q;
	assign channel_index = chan_q;
	assign chunk_end     = end_q;
	assign peak_level    = end_q ? pk_q : '0;
	assign rms_level     = end_q ? root_q[AMP_W-1:0] : '0;

	`ASSERT_ON(a_chan_range, clk, arst_n, CHCFG_W'(chan_q) < chans_eff)
	`ASSERT_ON(a_div_rem, clk, arst_n, (cmd.op == DP_DIV) |-> (drem_q < len_eff))
	`ASSERT_ON(a_chan_wrap, clk, arst_n, (cmd.advance && last_chan) |=> (chan_q == '0))

endmodule

@@ hdl/sine_tone_generator_with_level_stats.sv @@
// Top level of the sine tone generator with chunk peak and RMS statistics.
// Depends on stg_pkg, stg_ctrl and stg_datapath.
//
// Each accepted transaction with tick set produces one sine sample, sent once per
// channel as channel_count output transactions; a transaction with tick clear is
// taken and ignored. After a tick is accepted, the single 31x31 multiplier runs the
// nine multiply/write-back steps of sine evaluation, scaling and squaring before the
// first output transaction, then the output takes one cycle per channel copy when
// the sink is ready. On the tick that closes a chunk, the 42-step bit-serial
// divider and the 21-step square root run before the first output transaction.
// The next tick is taken after the last channel copy has been delivered.
module sine_tone_generator_with_level_stats (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [0] tick, [7:1] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // [15:0] sample, [30:16] peak_level,
	                                   // [45:31] rms_level, [47:46] zero
	output logic        m_axis_tlast,  // last_channel
	output logic [3:0]  m_axis_tuser,  // [2:0] channel_index, [3] chunk_end
	input  logic        cfg_we,
	input  logic [stg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [stg_pkg::CFG_DATA_W-1:0] cfg_data
);
	import stg_pkg::*;

	dp_cmd_t                    cmd;
	dp_sts_t                    sts;
	logic signed [SAMPLE_W-1:0] sample;
	logic [CHAN_W-1:0]          channel_index;
	logic                       chunk_end;
	logic [AMP_W-1:0]           peak_level;
	logic [AMP_W-1:0]           rms_level;

	stg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_tick   (s_axis_tdata[0]),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	stg_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.sts           (sts),
		.sample        (sample),
		.channel_index (channel_index),
		.chunk_end     (chunk_end),
		.peak_level    (peak_level),
		.rms_level     (rms_level)
	);

	assign m_axis_tdata = {2'b00, rms_level, peak_level, sample};
	assign m_axis_tlast = sts.last_chan;
	assign m_axis_tuser = {chunk_end, channel_index};

endmodule
